@@ rtl/core/dps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int ID_W          = 8;
    localparam int TIME_W        = 8;
    localparam int PRIO_W        = 12;
    localparam int BASE_W        = 8;
    localparam int AGING_W       = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [BASE_W-1:0]  PRIO_BASE_RST = 8'd50;
    localparam logic [AGING_W-1:0] AGING_RST     = 4'd3;
    localparam logic [PRIO_W-1:0]  PRIO_MIN      = 12'h800;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING_STEP    = 1'b1;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [1:0] STAT_ADDED    = 2'd0;
    localparam logic [1:0] STAT_REJECTED = 2'd1;
    localparam logic [1:0] STAT_RAN      = 2'd2;
    localparam logic [1:0] STAT_IDLE     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] need;
        logic [TIME_W-1:0] cpu;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } q_op_t;

    typedef struct packed {
        q_op_t  op;
        entry_t ins;
    } q_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_AGE,
        ST_RESOLVE,
        ST_REINS,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/dynamic_priority_scheduler.sv @@
// add: result goes out via ST_OUT; tick: DISP, AGE, RESOLVE if a task runs, REINS on preemption, then OUT
// one word in flight at a time; ST_OUT holds while an earlier result waits for m_ready
// queue is a chain of cells; insert and pop each update all cells in parallel
// the sequencer has a state each for dispatch, aging, resolve and reinsert
// synchronous active-low reset empties the queue, clears the running task, restores registers
`timescale 1ns / 1ps
`default_nettype none

module dynamic_priority_scheduler #(
    parameter int MAX_TASKS = dps_pkg::MAX_TASKS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [dps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic [dps_pkg::ID_W-1:0]          s_task_id,
    input  wire logic [dps_pkg::TIME_W-1:0]        s_need_time,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic [dps_pkg::ID_W-1:0]               m_ran_id,
    output logic [dps_pkg::TIME_W-1:0]             m_ran_cpu_time,
    output logic [dps_pkg::TIME_W-1:0]             m_ran_remaining,
    output logic signed [dps_pkg::PRIO_W-1:0]      m_ran_priority,
    output logic                                   m_ran_finished,
    output logic [dps_pkg::ID_W-1:0]               m_next_id,
    output logic                                   m_next_valid
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    dps_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            act_valid_reg, act_valid_next;
    dps_pkg::entry_t act_reg, act_next;
    dps_pkg::entry_t pre_reg, pre_next;
    logic [1:0]      res_status_reg, res_status_next;
    dps_pkg::entry_t res_ran_reg, res_ran_next;
    logic            res_fin_reg, res_fin_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_status_reg, m_status_next;
    dps_pkg::entry_t m_ran_reg, m_ran_next;
    logic            m_fin_reg, m_fin_next;
    logic [dps_pkg::ID_W-1:0] m_next_id_reg, m_next_id_next;
    logic            m_next_valid_reg, m_next_valid_next;
    logic [dps_pkg::BASE_W-1:0]  base_reg;
    logic [dps_pkg::AGING_W-1:0] aging_reg;

    dps_pkg::q_ctrl_t q_ctrl;
    dps_pkg::entry_t  head;
    dps_pkg::entry_t  new_entry;
    dps_pkg::entry_t  aged;
    logic [dps_pkg::PRIO_W:0] prio_wide;
    logic             full;

    dps_queue #(
        .MAX_TASKS (MAX_TASKS),
        .CW        (CW)
    ) u_queue (
        .aclk  (aclk),
        .ctrl  (q_ctrl),
        .count (count_reg),
        .head  (head)
    );

    assign s_ready = (state_reg == dps_pkg::ST_IDLE);
    assign full    = (count_reg == CW'(MAX_TASKS));

    assign new_entry.id   = s_task_id;
    assign new_entry.need = s_need_time;
    assign new_entry.cpu  = '0;
    assign new_entry.prio = {4'b0, base_reg} - {4'b0, s_need_time};

    // aging with saturation at the priority floor
    assign prio_wide = {act_reg.prio[dps_pkg::PRIO_W-1], act_reg.prio}
                       - {{(dps_pkg::PRIO_W + 1 - dps_pkg::AGING_W){1'b0}}, aging_reg};

    always_comb begin
        aged.id   = act_reg.id;
        aged.cpu  = (act_reg.cpu == '1) ? act_reg.cpu : act_reg.cpu + 1'b1;
        aged.need = (act_reg.need != '0) ? act_reg.need - 1'b1 : act_reg.need;
        aged.prio = (prio_wide[dps_pkg::PRIO_W] != prio_wide[dps_pkg::PRIO_W-1])
                    ? dps_pkg::PRIO_MIN : prio_wide[dps_pkg::PRIO_W-1:0];
    end

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        act_valid_next    = act_valid_reg;
        act_next          = act_reg;
        pre_next          = pre_reg;
        res_status_next   = res_status_reg;
        res_ran_next      = res_ran_reg;
        res_fin_next      = res_fin_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_ran_next        = m_ran_reg;
        m_fin_next        = m_fin_reg;
        m_next_id_next    = m_next_id_reg;
        m_next_valid_next = m_next_valid_reg;
        q_ctrl.op         = dps_pkg::OP_HOLD;
        q_ctrl.ins        = pre_reg;

        case (state_reg)
            dps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == dps_pkg::MODE_TICK) begin
                        state_next = dps_pkg::ST_DISP;
                    end else begin
                        res_ran_next = '0;
                        res_fin_next = 1'b0;
                        if (s_need_time == '0 || full) begin
                            res_status_next = dps_pkg::STAT_REJECTED;
                        end else begin
                            q_ctrl.op       = dps_pkg::OP_INSERT;
                            q_ctrl.ins      = new_entry;
                            count_next      = count_reg + 1'b1;
                            res_status_next = dps_pkg::STAT_ADDED;
                        end
                        state_next = dps_pkg::ST_OUT;
                    end
                end
            end
            dps_pkg::ST_DISP: begin
                if (!act_valid_reg && count_reg != '0) begin
                    act_next       = head;
                    act_valid_next = 1'b1;
                    q_ctrl.op      = dps_pkg::OP_POP;
                    count_next     = count_reg - 1'b1;
                end
                state_next = dps_pkg::ST_AGE;
            end
            dps_pkg::ST_AGE: begin
                if (!act_valid_reg) begin
                    res_status_next = dps_pkg::STAT_IDLE;
                    res_ran_next    = '0;
                    res_fin_next    = 1'b0;
                    state_next      = dps_pkg::ST_OUT;
                end else begin
                    act_next        = aged;
                    res_status_next = dps_pkg::STAT_RAN;
                    res_ran_next    = aged;
                    res_fin_next    = (aged.need == '0);
                    state_next      = dps_pkg::ST_RESOLVE;
                end
            end
            dps_pkg::ST_RESOLVE: begin
                state_next = dps_pkg::ST_OUT;
                if (act_reg.need == '0) begin
                    act_valid_next = 1'b0;
                    if (count_reg != '0) begin
                        act_next       = head;
                        act_valid_next = 1'b1;
                        q_ctrl.op      = dps_pkg::OP_POP;
                        count_next     = count_reg - 1'b1;
                    end
                end else if (count_reg != '0
                             && $signed(head.prio) > $signed(act_reg.prio)) begin
                    pre_next   = act_reg;
                    act_next   = head;
                    q_ctrl.op  = dps_pkg::OP_POP;
                    count_next = count_reg - 1'b1;
                    state_next = dps_pkg::ST_REINS;
                end
            end
            dps_pkg::ST_REINS: begin
                q_ctrl.op  = dps_pkg::OP_INSERT;
                q_ctrl.ins = pre_reg;
                count_next = count_reg + 1'b1;
                state_next = dps_pkg::ST_OUT;
            end
            dps_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_ran_next        = res_ran_reg;
                    m_fin_next        = res_fin_reg;
                    m_next_valid_next = act_valid_reg;
                    m_next_id_next    = act_valid_reg ? act_reg.id : '0;
                    state_next        = dps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dps_pkg::ST_IDLE;
            count_reg     <= '0;
            act_valid_reg <= 1'b0;
            act_reg       <= '0;
            m_valid_reg   <= 1'b0;
            base_reg      <= dps_pkg::PRIO_BASE_RST;
            aging_reg     <= dps_pkg::AGING_RST;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            act_valid_reg <= act_valid_next;
            act_reg       <= act_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    dps_pkg::CFG_PRIORITY_BASE: base_reg  <= cfg_wdata;
                    dps_pkg::CFG_AGING_STEP:    aging_reg <= cfg_wdata[dps_pkg::AGING_W-1:0];
                    default: begin
                        base_reg <= base_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pre_reg          <= pre_next;
        res_status_reg   <= res_status_next;
        res_ran_reg      <= res_ran_next;
        res_fin_reg      <= res_fin_next;
        m_status_reg     <= m_status_next;
        m_ran_reg        <= m_ran_next;
        m_fin_reg        <= m_fin_next;
        m_next_id_reg    <= m_next_id_next;
        m_next_valid_reg <= m_next_valid_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_ran_id        = m_ran_reg.id;
    assign m_ran_cpu_time  = m_ran_reg.cpu;
    assign m_ran_remaining = m_ran_reg.need;
    assign m_ran_priority  = m_ran_reg.prio;
    assign m_ran_finished  = m_fin_reg;
    assign m_next_id       = m_next_id_reg;
    assign m_next_valid    = m_next_valid_reg;

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctrl.op == dps_pkg::OP_INSERT |-> !full)
        else $error("insert into full queue");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctrl.op == dps_pkg::OP_POP |-> count_reg != '0)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_TASKS))
        else $error("queue count out of range");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

    a_next_id_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_next_valid |-> m_next_id == '0)
        else $error("next id set with no running task");

endmodule

`default_nettype wire

@@ rtl/core/dps_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dps_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic             aclk,
    input  wire dps_pkg::q_ctrl_t ctrl,
    input  wire logic [CW-1:0]    count,
    input  wire dps_pkg::entry_t  left_entry,
    input  wire logic             left_ge,
    input  wire dps_pkg::entry_t  right_entry,
    output dps_pkg::entry_t       entry,
    output logic                  ge
);

    dps_pkg::entry_t entry_reg;
    dps_pkg::entry_t entry_next;
    logic            occupied;

    assign occupied = count > CW'(IDX);
    assign ge       = occupied && ($signed(entry_reg.prio) >= $signed(ctrl.ins.prio));
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            dps_pkg::OP_INSERT: begin
                if (!ge) begin
                    entry_next = left_ge ? ctrl.ins : left_entry;
                end
            end
            dps_pkg::OP_POP: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/dps_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dps_queue #(
    parameter int MAX_TASKS = dps_pkg::MAX_TASKS_DEF,
    parameter int CW        = $clog2(MAX_TASKS + 1)
) (
    input  wire logic             aclk,
    input  wire dps_pkg::q_ctrl_t ctrl,
    input  wire logic [CW-1:0]    count,
    output dps_pkg::entry_t       head
);

    dps_pkg::entry_t ent [MAX_TASKS];
    logic            ge  [MAX_TASKS];

    genvar i;
    generate
        for (i = 0; i < MAX_TASKS; i++) begin : g_cell
            dps_pkg::entry_t left_e;
            dps_pkg::entry_t right_e;
            logic            left_g;

            if (i == 0) begin : g_first
                assign left_e = '0;
                assign left_g = 1'b1;
            end else begin : g_mid
                assign left_e = ent[i-1];
                assign left_g = ge[i-1];
            end

            if (i == MAX_TASKS - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_body
                assign right_e = ent[i+1];
            end

            dps_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .count       (count),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .entry       (ent[i]),
                .ge          (ge[i])
            );
        end
    endgenerate

    assign head = ent[0];

endmodule

`default_nettype wire
